FILE: rtl/bscd_pkg.sv
// ----------------------------------------------------------------------------
// bscd_pkg: shared types and constants for the byte-stuffed CRC-8 deframer
// Holds result codes, register indexes, reset values and the CRC-8 step.
// ----------------------------------------------------------------------------
`default_nettype none

package bscd_pkg;

  localparam int unsigned MAX_FRAME_DEF = 256;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [7:0] CRC_POLY       = 8'h07;
  localparam logic [7:0] LIMIT_RESET    = 8'h7E;
  localparam logic [7:0] ESCAPE_RESET   = 8'h7D;
  localparam logic [7:0] MASK_RESET     = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIMIT_BYTE  = 2'd0,
    REG_ESCAPE_BYTE = 2'd1,
    REG_ESCAPE_MASK = 2'd2
  } reg_idx_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_ESCAPE = 3'd1,
    ST_TOO_SMALL  = 3'd2,
    ST_BAD_CRC    = 3'd3,
    ST_TOO_BIG    = 3'd4
  } status_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_byte;
    status_t    status;
    logic [7:0] frame_length;
  } result_t;

  // One byte through CRC-8, MSB first, no final XOR.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bscd_if.sv
// ----------------------------------------------------------------------------
// bscd_if: valid/ready channels of the deframer
// Received byte stream, result stream and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface bscd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bscd_res_if;
  import bscd_pkg::*;
  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [7:0] payload_byte;
  status_t    status;
  logic [7:0] frame_length;

  modport source (output valid, output kind, output payload_byte, output status,
                  output frame_length, input ready);
  modport sink   (input valid, input kind, input payload_byte, input status,
                  input frame_length, output ready);
endinterface

interface bscd_cfg_if;
  import bscd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [7:0]           wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: rtl/byte_stuffed_crc8_deframer_unit.sv
// ----------------------------------------------------------------------------
// byte_stuffed_crc8_deframer_unit: byte-stuffed frame receiver with CRC-8
// Unescapes framed bytes, checks CRC-8 and emits payload and frame status.
// ----------------------------------------------------------------------------
// Usage:
//   rx   - one raw line byte per transaction. Bytes outside a frame are dropped
//          until a limit byte opens one.
//   res  - payload bytes (kind 0) delayed by one stored byte, so the trailing
//          CRC byte is never shown, then one frame end status (kind 1).
//   cfg  - writes limit_byte, escape_byte and escape_mask; always ready.
//          Write only while no transaction is in flight.
// Timing: every rx transaction is handled in the cycle it is accepted; any
//   result is registered in the output register, or in the skid register
//   while that stalls. One rx transaction per cycle is sustained while res
//   keeps up; compare, unescape and one CRC-8 byte step are combinational.
// Stall: a two-entry output buffer (output register plus skid register)
//   parts the two sides; rx.ready drops only when both entries hold results.
// Reset: rst (synchronous) returns to hunting, clears the CRC and count,
//   empties the output buffer and restores register defaults 0x7E/0x7D/0x20.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stuffed_crc8_deframer_unit #(
  parameter int unsigned MAX_FRAME = bscd_pkg::MAX_FRAME_DEF
) (
  input  wire        clk,
  input  wire        rst,
  bscd_rx_if.sink    rx,
  bscd_res_if.source res,
  bscd_cfg_if.sink   cfg
);
  import bscd_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);

  // configuration registers
  logic [7:0] limit_byte;
  logic [7:0] escape_byte;
  logic [7:0] escape_mask;

  // frame state
  logic             in_frame, in_frame_next;
  logic             escape_pending, escape_pending_next;
  logic [7:0]       crc_accum, crc_accum_next;
  logic [CNT_W-1:0] stored_count, stored_count_next;
  logic [7:0]       held_byte, held_byte_next;

  // output buffer
  result_t out_data, skid_data, step_res;
  logic    out_valid, skid_valid;
  logic    step_emit;
  logic    accept, pop;

  logic [7:0]  unesc_byte;
  logic [31:0] len_wide;
  status_t     close_status;

  assign cfg.ready = 1'b1;
  assign rx.ready  = !skid_valid;
  assign accept    = rx.valid && rx.ready;
  assign pop       = out_valid && res.ready;

  assign res.valid        = out_valid;
  assign res.kind         = out_data.kind;
  assign res.payload_byte = out_data.payload_byte;
  assign res.status       = out_data.status;
  assign res.frame_length = out_data.frame_length;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_byte  <= LIMIT_RESET;
      escape_byte <= ESCAPE_RESET;
      escape_mask <= MASK_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.reg_index)
        REG_LIMIT_BYTE:  limit_byte  <= cfg.wdata;
        REG_ESCAPE_BYTE: escape_byte <= cfg.wdata;
        REG_ESCAPE_MASK: escape_mask <= cfg.wdata;
        default: ;
      endcase
    end
  end

  assign unesc_byte = escape_pending ? (rx.rx_byte ^ escape_mask) : rx.rx_byte;
  // stored bytes minus the CRC byte; saturated to eight bits at the close
  assign len_wide   = 32'(stored_count) - 32'd1;

  always_comb begin
    if (escape_pending) begin
      close_status = ST_BAD_ESCAPE;
    end else if (stored_count == '0) begin
      close_status = ST_TOO_SMALL;
    end else if (crc_accum != 8'h00) begin
      close_status = ST_BAD_CRC;
    end else begin
      close_status = ST_OK;
    end
  end

  // One rx byte against the frame state.
  always_comb begin
    in_frame_next       = in_frame;
    escape_pending_next = escape_pending;
    crc_accum_next      = crc_accum;
    stored_count_next   = stored_count;
    held_byte_next      = held_byte;
    step_emit           = 1'b0;
    step_res            = '{kind: KIND_PAYLOAD, payload_byte: 8'h00, status: ST_OK,
                            frame_length: 8'h00};
    if (!in_frame) begin
      // hunting: only a limit byte opens a frame
      if (rx.rx_byte == limit_byte) begin
        in_frame_next       = 1'b1;
        escape_pending_next = 1'b0;
        crc_accum_next      = 8'h00;
        stored_count_next   = '0;
      end
    end else if (rx.rx_byte == limit_byte) begin
      step_emit       = 1'b1;
      step_res.kind   = KIND_END;
      step_res.status = close_status;
      escape_pending_next = 1'b0;
      crc_accum_next      = 8'h00;
      stored_count_next   = '0;
      if (close_status == ST_OK) begin
        step_res.frame_length = (len_wide > 32'd255) ? 8'hFF : len_wide[7:0];
        in_frame_next         = 1'b0;
      end
      // on error the same limit byte opens the next frame: stay in frame
    end else if (stored_count == CNT_W'(MAX_FRAME)) begin
      // overflow: drop the byte and go back to hunting
      step_emit           = 1'b1;
      step_res.kind       = KIND_END;
      step_res.status     = ST_TOO_BIG;
      in_frame_next       = 1'b0;
      escape_pending_next = 1'b0;
      crc_accum_next      = 8'h00;
      stored_count_next   = '0;
    end else if (rx.rx_byte == escape_byte) begin
      escape_pending_next = 1'b1;
    end else begin
      escape_pending_next = 1'b0;
      crc_accum_next      = crc8_update(crc_accum, unesc_byte);
      held_byte_next      = unesc_byte;
      stored_count_next   = stored_count + CNT_W'(1);
      // release the previously held byte
      if (stored_count != '0) begin
        step_emit             = 1'b1;
        step_res.payload_byte = held_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      escape_pending <= 1'b0;
      crc_accum      <= 8'h00;
      stored_count   <= '0;
    end else if (accept) begin
      in_frame       <= in_frame_next;
      escape_pending <= escape_pending_next;
      crc_accum      <= crc_accum_next;
      stored_count   <= stored_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= held_byte_next;
    end
  end

  // Two-entry output buffer; skid fills only while the output register stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid) begin
        out_valid <= accept && step_emit;
      end else if (pop) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          out_valid <= accept && step_emit;
        end
      end else if (accept && step_emit) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : step_res;
    end
    if (out_valid && !pop && accept && step_emit) begin
      skid_data <= step_res;
    end
  end

`ifndef SYNTH
  // skid entry is only ever used behind a full output register
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry valid with empty output register");

  // stored byte count never passes the frame limit
  assert property (@(posedge clk) disable iff (rst)
                   32'(stored_count) <= MAX_FRAME)
    else $error("stored count exceeds MAX_FRAME");

  // hunting state carries no frame context
  assert property (@(posedge clk) disable iff (rst)
                   !in_frame |-> (stored_count == '0 && !escape_pending && crc_accum == 8'h00))
    else $error("frame context left over while hunting");

  // a stalled result is not overwritten
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && !res.ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

FILE: bench/byte_stuffed_crc8_deframer_unit_tb.sv
// ----------------------------------------------------------------------------
// byte_stuffed_crc8_deframer_unit_tb: self-checking bench for the deframer
// Drives raw line bytes and register writes under random gaps and output
// stalls. A bit-true software deframer predicts each payload byte and each
// frame end status, and every result transaction is checked against it.
// ----------------------------------------------------------------------------
module byte_stuffed_crc8_deframer_unit_tb;
  import bscd_pkg::*;

  localparam int unsigned FRAME_CAP   = MAX_FRAME_DEF;
  localparam logic [7:0]  CRC8_POLY   = 8'h07;
  localparam int          HOLD_CYCLES = 80;    // long receiver hold-off
  localparam int          SETTLE      = 4;     // extra idle after the last result
  localparam int          QUIET_LIMIT = 1000;  // cycles with no transaction
  localparam int          SHOWN_FAULTS = 10;

  typedef logic [7:0] octet_q_t [$];

  logic clk = 1'b0;
  logic rst = 1'b1;

  bscd_rx_if  rx_if ();
  bscd_res_if res_if ();
  bscd_cfg_if cfg_if ();

  byte_stuffed_crc8_deframer_unit #(
    .MAX_FRAME(FRAME_CAP)
  ) uut (
    .clk(clk),
    .rst(rst),
    .rx (rx_if),
    .res(res_if),
    .cfg(cfg_if)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow copy of the registers and of the deframer state
  // --------------------------------------------------------------------------
  logic [7:0] lim_reg  = LIMIT_RESET;
  logic [7:0] esc_reg  = ESCAPE_RESET;
  logic [7:0] mask_reg = MASK_RESET;

  logic       fr_open   = 1'b0;   // inside a frame, else hunting
  logic       esc_seen  = 1'b0;   // escape marker waiting for its byte
  logic [7:0] crc_acc   = 8'h00;
  int         fill_count = 0;     // unescaped bytes stored in this frame
  logic [7:0] last_byte = 8'h00;  // stored byte not yet shown as payload

  result_t pending_results [$];   // predicted results, oldest first
  int      fault_count  = 0;
  int      framed_bytes = 0;      // bytes taken in a frame or as a limit

  // Stimulus controls
  bit jitter_on    = 1'b1;
  bit hold_request = 1'b0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  // CRC-8, poly 0x07, MSB first: shift one data bit at a time.
  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] d);
    logic [7:0] r;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      if (r[7] ^ d[k]) begin
        r = {r[6:0], 1'b0} ^ CRC8_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Advance the shadow deframer by one accepted line byte; queue its result.
  task automatic deframe_step(input logic [7:0] b);
    result_t    r;
    status_t    st;
    logic [7:0] v;
    r = '0;
    r.kind = KIND_END;
    r.status = ST_OK;
    if (fr_open || b == lim_reg) begin
      framed_bytes++;
    end
    if (!fr_open) begin
      // Hunting: only a limit byte matters, and it opens a frame.
      if (b == lim_reg) begin
        fr_open = 1'b1; esc_seen = 1'b0; crc_acc = 8'h00; fill_count = 0;
      end
    end else if (b == lim_reg) begin
      // Closing limit: pick the status by priority.
      if (esc_seen) st = ST_BAD_ESCAPE;
      else if (fill_count == 0) st = ST_TOO_SMALL;
      else if (crc_acc != 8'h00) st = ST_BAD_CRC;
      else st = ST_OK;
      r.status = st;
      if (st == ST_OK) begin
        r.frame_length = (fill_count - 1 > 255) ? 8'hFF : 8'(fill_count - 1);
        fr_open = 1'b0;
      end
      // Either way the accumulators restart; an error keeps the frame open.
      esc_seen = 1'b0; crc_acc = 8'h00; fill_count = 0;
      pending_results.push_back(r);
    end else if (fill_count >= FRAME_CAP) begin
      // Frame overflow: drop the byte and go back to hunting.
      r.status = ST_TOO_BIG;
      fr_open = 1'b0; esc_seen = 1'b0; crc_acc = 8'h00; fill_count = 0;
      pending_results.push_back(r);
    end else if (b == esc_reg) begin
      esc_seen = 1'b1;
    end else begin
      v = esc_seen ? (b ^ mask_reg) : b;
      esc_seen = 1'b0;
      crc_acc = crc8_next(crc_acc, v);
      if (fill_count > 0) begin
        r.kind = KIND_PAYLOAD;
        r.payload_byte = last_byte;
        pending_results.push_back(r);
      end
      last_byte = v;
      fill_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: register writes, line bytes and results, all at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (reg_idx_t'(cfg_if.reg_index))
          REG_LIMIT_BYTE:  lim_reg  = cfg_if.wdata;
          REG_ESCAPE_BYTE: esc_reg  = cfg_if.wdata;
          REG_ESCAPE_MASK: mask_reg = cfg_if.wdata;
          default: ;
        endcase
      end
      // Predict first so a same-edge result still finds its expectation.
      if (rx_if.valid && rx_if.ready) begin
        deframe_step(rx_if.rx_byte);
      end
      if (res_if.valid && res_if.ready) begin
        got.kind         = res_if.kind;
        got.payload_byte = res_if.payload_byte;
        got.status       = res_if.status;
        got.frame_length = res_if.frame_length;
        if (pending_results.size() == 0) begin
          fault_count++;
          if (fault_count <= SHOWN_FAULTS) begin
            $display("unexpected result: kind=%0d byte=%02h status=%0d len=%0d",
                     got.kind, got.payload_byte, got.status, got.frame_length);
          end
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
              got.status !== want.status || got.frame_length !== want.frame_length) begin
            fault_count++;
            if (fault_count <= SHOWN_FAULTS) begin
              $display("mismatch: expected kind=%0d byte=%02h status=%0d len=%0d",
                       want.kind, want.payload_byte, want.status, want.frame_length);
              $display("          got      kind=%0d byte=%02h status=%0d len=%0d",
                       got.kind, got.payload_byte, got.status, got.frame_length);
            end
          end
        end
      end
    end
  end

  // Watchdog: end the run when no transaction of any kind moves for too long.
  always @(posedge clk) begin
    if (rst || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      res_if.ready = 1'b0;
      hold_left--;
    end else begin
      res_if.ready = !(jitter_on && $urandom_range(99) < 17);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers (all entered and left at a falling edge)
  // --------------------------------------------------------------------------

  // Offer one line byte, idling first at random; return once it is taken.
  task automatic send_byte(input logic [7:0] b);
    while (jitter_on && $urandom_range(99) < 17) begin
      rx_if.valid = 1'b0;
      @(negedge clk);
    end
    rx_if.valid   = 1'b1;
    rx_if.rx_byte = b;
    do @(posedge clk); while (!rx_if.ready);
    @(negedge clk);
  endtask

  // Escape a byte that would read as a limit or an escape marker.
  task automatic send_stuffed(input logic [7:0] v);
    if (v == lim_reg || v == esc_reg) begin
      send_byte(esc_reg);
      send_byte(v ^ mask_reg);
    end else begin
      send_byte(v);
    end
  endtask

  // Send limit bytes until an empty frame is open.
  task automatic open_frame();
    while (!(fr_open && fill_count == 0 && !esc_seen)) begin
      send_byte(lim_reg);
    end
  endtask

  // Send a frame body with its CRC byte; optionally corrupt one CRC bit and
  // leave the frame unclosed.
  task automatic send_body(input octet_q_t body, input bit bad_crc, input bit add_close);
    logic [7:0] acc;
    acc = 8'h00;
    open_frame();
    foreach (body[i]) begin
      acc = crc8_next(acc, body[i]);
      send_stuffed(body[i]);
    end
    if (bad_crc) begin
      acc = acc ^ (8'h01 << $urandom_range(7));
    end
    send_stuffed(acc);
    if (add_close) begin
      send_byte(lim_reg);
    end
  endtask

  // Lean toward the marker values and the extremes.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 10) return lim_reg;
    if (r < 20) return esc_reg;
    if (r < 25) return 8'h00;
    if (r < 30) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_frame(input int n_pay, input bit bad_crc, input bit add_close);
    octet_q_t body;
    repeat (n_pay) body.push_back(pick_byte());
    send_body(body, bad_crc, add_close);
  endtask

  // Drop valid and wait until every predicted result has arrived.
  task automatic drain_results();
    rx_if.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
    drain_results();
    cfg_if.reg_index = idx;
    cfg_if.wdata     = val;
    cfg_if.valid     = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic set_markers(input logic [7:0] lim, input logic [7:0] esc,
                             input logic [7:0] mask);
    write_reg(REG_LIMIT_BYTE, lim);
    write_reg(REG_ESCAPE_BYTE, esc);
    write_reg(REG_ESCAPE_MASK, mask);
  endtask

  // Mostly well-formed frames with random content; the rest is broken
  // frames and raw noise. Stop once n more bytes fell in a frame or were limits.
  task automatic run_traffic(input int n);
    int start;
    int pick;
    start = framed_bytes;
    while (framed_bytes - start < n) begin
      pick = $urandom_range(99);
      if (pick < 68) begin
        send_frame(($urandom_range(99) < 5) ? 60 : $urandom_range(12), 1'b0, 1'b1);
      end else if (pick < 78) begin
        send_frame($urandom_range(12, 1), 1'b1, 1'b1);
      end else if (pick < 84) begin
        // Escape right before the closing limit.
        send_frame($urandom_range(6), 1'b0, 1'b0);
        send_byte(esc_reg);
        send_byte(lim_reg);
      end else if (pick < 92) begin
        repeat ($urandom_range(6, 1)) send_byte(pick_byte());
      end else if (pick < 97) begin
        send_byte(lim_reg);
        send_byte(lim_reg);
      end else begin
        hold_request = 1'b1;
        send_frame($urandom_range(20, 4), 1'b0, 1'b1);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Drop anything but a limit while hunting, escape markers included.
  task automatic test_hunting_noise();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ESCAPE_RESET);
    send_byte(8'h55);
  endtask

  // Back-to-back limits give too small; a lone zero CRC byte is a valid
  // empty frame.
  task automatic test_short_frames();
    send_byte(lim_reg);
    send_byte(lim_reg);
    send_byte(8'h00);
    send_byte(lim_reg);
  endtask

  // Stuffed marker values, a repeated escape, and an escape at the close.
  task automatic test_escapes();
    octet_q_t body;
    body = '{LIMIT_RESET, ESCAPE_RESET, 8'hFF};
    send_body(body, 1'b0, 1'b1);
    // Two escapes in a row still unescape the next byte only once.
    open_frame();
    send_byte(esc_reg);
    send_byte(esc_reg);
    send_byte(LIMIT_RESET ^ mask_reg);
    send_stuffed(crc8_next(8'h00, LIMIT_RESET));
    send_byte(lim_reg);
    // Escape pending at the limit; that limit opens the next frame.
    open_frame();
    send_byte(8'h41);
    send_byte(esc_reg);
    send_byte(lim_reg);
  endtask

  task automatic test_bad_crc();
    octet_q_t body;
    body = '{8'h00, 8'hFF};
    send_body(body, 1'b1, 1'b1);
  endtask

  // Largest legal frame, then a full store overflowed by an escape marker.
  // Both sides run without idling here.
  task automatic test_frame_size_limits();
    octet_q_t body;
    for (int i = 0; i < FRAME_CAP - 1; i++) begin
      body.push_back(8'(i));
    end
    jitter_on = 1'b0;
    send_body(body, 1'b0, 1'b1);
    send_body(body, 1'b0, 1'b0);
    send_byte(esc_reg);
    jitter_on = 1'b1;
  endtask

  // Hold the receiver off while a frame keeps coming, so the input stalls.
  task automatic test_output_backpressure();
    jitter_on = 1'b0;
    hold_request = 1'b1;
    send_frame(24, 1'b0, 1'b1);
    jitter_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    jitter_on = 1'b0;
    run_traffic(30);
    jitter_on = 1'b1;
    run_traffic(50);
  endtask

  // Extreme, overlapping and random marker settings.
  task automatic test_register_settings();
    set_markers(8'h00, 8'hFF, 8'hFF);
    run_traffic(12);
    set_markers(8'hFF, 8'h00, 8'h00);
    run_traffic(12);
    set_markers(8'h55, 8'h55, 8'h80);
    run_traffic(12);
    set_markers(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    run_traffic(12);
  endtask

  initial begin
    rx_if.valid      = 1'b0;
    rx_if.rx_byte    = 8'h00;
    res_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_index = REG_LIMIT_BYTE;
    cfg_if.wdata     = 8'h00;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_hunting_noise();
    test_short_frames();
    test_escapes();
    test_bad_crc();
    test_frame_size_limits();
    test_output_backpressure();
    test_random_traffic();
    test_register_settings();

    drain_results();
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: byte_stuffed_crc8_deframer_unit.f
rtl/bscd_pkg.sv
rtl/bscd_if.sv
rtl/byte_stuffed_crc8_deframer_unit.sv
bench/byte_stuffed_crc8_deframer_unit_tb.sv
